// ----- rtl/dpws_pkg.sv -----
package dpws_pkg;

  // tap amplitude width, fixed by the request layout below
  localparam int AMP_BITS = 16;

  typedef struct packed {
    logic        op;
    logic [7:0]  tap_index;
    logic [15:0] amp_re;
    logic [15:0] amp_im;
    logic        coherent;
    logic        from_peak;
    logic [31:0] time_first;
    logic [31:0] time_second;
  } dpws_in_t;

  typedef struct packed {
    logic [23:0] sum_re;
    logic [23:0] sum_im;
    logic [23:0] sum_mag;
  } dpws_out_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV1,
    ST_DIV2,
    ST_PEAK,
    ST_BOUND,
    ST_SUM,
    ST_SQRT,
    ST_DONE
  } dpws_state_t;

  // datapath commands
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div1_start;
    logic div2_start;
    logic div_step;
    logic peak_start;
    logic peak_step;
    logic bound;
    logic sum_start;
    logic sum_step;
    logic sqrt_start;
    logic sqrt_step;
    logic sqrt_acc;
    logic emit;
  } dpws_cmd_t;

  // datapath status
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic peak_done;
    logic sum_done;
    logic sqrt_done;
    logic res_zero;
    logic is_query;
    logic from_peak;
    logic coherent;
  } dpws_sts_t;

endpackage

// ----- rtl/dpws_ram.sv -----
module dpws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dpws_ctrl.sv -----
module dpws_ctrl import dpws_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  logic      out_free,
  input  dpws_sts_t sts,
  output dpws_cmd_t cmd,
  output logic      busy
);

  dpws_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (!sts.is_query) state_nxt = ST_IDLE;
        else if (sts.res_zero) state_nxt = ST_BOUND;
        else if (sts.div_done) state_nxt = ST_DIV2;
      end
      ST_DIV2: if (sts.div_done) state_nxt = sts.from_peak ? ST_PEAK : ST_BOUND;
      ST_PEAK: if (sts.peak_done) state_nxt = ST_BOUND;
      ST_BOUND: state_nxt = ST_SUM;
      ST_SUM: begin
        if (sts.sum_done) state_nxt = ST_DONE;
        else if (!sts.coherent) state_nxt = ST_SQRT;
      end
      ST_SQRT: if (sts.sqrt_done) state_nxt = ST_SUM;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic div_first_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_first_r <= 1'b0;
    end else begin
      div_first_r <= (state_r == ST_IDLE && in_fire) ||
                     (state_r == ST_DIV1 && sts.div_done && !sts.res_zero);
    end
  end

  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE:  cmd.load = in_fire;
      ST_DIV1: begin
        cmd.div1_start = div_first_r;
        cmd.div_step = !div_first_r;
        if (sts.div_done && !sts.res_zero) cmd.div2_start = 1'b1;
      end
      ST_DIV2: begin
        cmd.div_step = !div_first_r;
        if (sts.div_done && sts.from_peak) cmd.peak_start = 1'b1;
      end
      ST_PEAK:  cmd.peak_step = 1'b1;
      ST_BOUND: begin
        cmd.bound = 1'b1;
        cmd.sum_start = 1'b1;
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        cmd.sqrt_start = !sts.coherent && !sts.sum_done;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.sqrt_acc = sts.sqrt_done;
      end
      ST_DONE:  cmd.emit = out_free;
      default:  cmd = '0;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SQRT |-> !sts.coherent)
    else $error("sqrt on coherent query");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == ST_IDLE)
    else $error("emit without return to idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == ST_IDLE)
    else $error("request taken while busy");

endmodule

// ----- rtl/dpws_dp.sv -----
module dpws_dp import dpws_pkg::*; #(
  parameter int MAX_TAPS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dpws_in_t    in_data,
  input  logic [31:0] res_ticks,
  input  dpws_cmd_t   cmd,
  output dpws_sts_t   sts,
  output dpws_out_t   result
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int MW = 2 * AMP_BITS;

  dpws_in_t req_r;
  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_data;
  end

  // tap store, cleared by a sweep after reset
  logic [AW:0]           clr_r;
  logic [CW-1:0]         cnt_r;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [2*AMP_BITS-1:0] wdata, rdata;
  logic                  wr_ok;

  assign wr_ok = ({24'd0, in_data.tap_index} < 32'(MAX_TAPS));
  assign we    = cmd.clr_step || (cmd.load && in_data.op == OP_WRITE && wr_ok);
  assign waddr = cmd.clr_step ? clr_r[AW-1:0] : AW'(in_data.tap_index);
  assign wdata = cmd.clr_step ? '0 :
                 {in_data.amp_re[AMP_BITS-1:0], in_data.amp_im[AMP_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.load && in_data.op == OP_WRITE && wr_ok &&
          {1'b0, cnt_r} < (CW+1)'(in_data.tap_index) + 1'b1) begin
        cnt_r <= CW'(in_data.tap_index) + 1'b1;
      end
    end
  end

  dpws_ram #(.WIDTH(2*AMP_BITS), .DEPTH(MAX_TAPS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // restoring divider, one quotient bit a cycle
  logic [33:0] dnum_r;
  logic [32:0] drem_r;
  logic [31:0] dquo_r;
  logic [5:0]  dcnt_r;
  logic        dmode_r;
  logic [33:0] dden;
  logic [34:0] dtrial;
  logic [33:0] q1_r;

  assign dden   = dmode_r ? {1'b0, res_ticks, 1'b0} : {2'b0, res_ticks};
  assign dtrial = {drem_r, dnum_r[33]} - {1'b0, dden};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dcnt_r <= '0;
    end else if (cmd.div1_start || cmd.div2_start) begin
      dcnt_r <= '0;
      drem_r <= '0;
      dquo_r <= '0;
      if (cmd.div1_start) begin
        dmode_r <= !req_r.from_peak;
        dnum_r  <= req_r.from_peak ? {2'b0, req_r.time_first}
                                   : {1'b0, req_r.time_first, 1'b0} + {2'b0, res_ticks};
      end else begin
        dmode_r <= 1'b1;
        dnum_r  <= {1'b0, req_r.time_second, 1'b0} + {2'b0, res_ticks};
        q1_r    <= {2'b0, dquo_r};
      end
    end else if (cmd.div_step && dcnt_r != 6'd34) begin
      dcnt_r <= dcnt_r + 1'b1;
      dnum_r <= {dnum_r[32:0], 1'b0};
      if (!dtrial[34]) begin
        drem_r <= dtrial[32:0];
        dquo_r <= {dquo_r[30:0], 1'b1};
      end else begin
        drem_r <= {drem_r[31:0], dnum_r[33]};
        dquo_r <= {dquo_r[30:0], 1'b0};
      end
    end
  end

  // peak search: address issued the cycle before its registered read data
  logic [CW:0]     pidx_r;
  logic [AW-1:0]   pk_r, pcand_r;
  logic [MW:0]     best_r;
  logic            pvld_r;
  logic [MW:0]     msq;
  logic signed [AMP_BITS-1:0] rre, rim;
  logic signed [MW-1:0]       xre, xim;
  logic [MW-1:0]              psq_re, psq_im;

  assign rre    = rdata[2*AMP_BITS-1:AMP_BITS];
  assign rim    = rdata[AMP_BITS-1:0];
  assign xre    = MW'(rre);
  assign xim    = MW'(rim);
  assign psq_re = $unsigned(xre * xre);
  assign psq_im = $unsigned(xim * xim);
  assign msq    = {1'b0, psq_re} + {1'b0, psq_im};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else if (cmd.peak_start) begin
      pidx_r <= '0;
      pk_r   <= '0;
      best_r <= '0;
      pvld_r <= 1'b0;
    end else if (cmd.peak_step) begin
      pvld_r  <= (pidx_r < (CW+1)'(cnt_r));
      pcand_r <= pidx_r[AW-1:0];
      if (pidx_r < (CW+1)'(cnt_r)) pidx_r <= pidx_r + 1'b1;
      if (pvld_r && msq > best_r) begin
        best_r <= msq;
        pk_r   <= pcand_r;
      end
    end
  end

  // window bounds
  logic [35:0] en_r, cur_r;
  logic [35:0] st_w, en_w;
  logic [35:0] lim;

  always_comb begin
    if (req_r.from_peak) begin
      st_w = 36'(pk_r) + 36'(q1_r);
      en_w = st_w + 36'(dquo_r);
    end else begin
      st_w = 36'(q1_r);
      en_w = 36'(dquo_r);
    end
    lim = (36'(cnt_r) < en_w) ? 36'(cnt_r) : en_w;
    if (res_ticks == '0) begin
      st_w = '0;
      lim = (req_r.from_peak || req_r.time_first == '0) ? 36'd1 : 36'd0;
    end
    if (lim > 36'(MAX_TAPS)) lim = 36'(MAX_TAPS);
  end

  // accumulation: read issued at sum_start or after each tap
  logic signed [23:0] acc_re_r, acc_im_r;
  logic [23:0]        acc_mag_r;
  logic               rd_wait_r;

  // bitwise integer square root
  logic [MW+1:0] sx_r, sres_r, sbit_r;
  logic [MW+1:0] strial;
  assign strial = sres_r + sbit_r;

  always_ff @(posedge clk) begin
    if (cmd.bound) begin
      en_r <= lim;
      cur_r <= st_w;
      acc_re_r <= '0;
      acc_im_r <= '0;
      acc_mag_r <= '0;
      rd_wait_r <= 1'b1;
    end else if (cmd.sum_step) begin
      if (rd_wait_r) begin
        rd_wait_r <= 1'b0;
      end else if (cur_r < en_r) begin
        cur_r <= cur_r + 1'b1;
        rd_wait_r <= 1'b1;
        if (req_r.coherent) begin
          acc_re_r <= acc_re_r + 24'(rre);
          acc_im_r <= acc_im_r + 24'(rim);
        end
      end
    end
    if (cmd.sqrt_start) begin
      sx_r   <= (MW+2)'(msq);
      sres_r <= '0;
      sbit_r <= (MW+2)'(1) << MW;
    end else if (cmd.sqrt_step && sbit_r != '0) begin
      if (sx_r >= strial) begin
        sx_r   <= sx_r - strial;
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
    if (cmd.sqrt_acc) begin
      acc_mag_r <= acc_mag_r + 24'(sres_r);
      cur_r <= cur_r + 1'b1;
      rd_wait_r <= 1'b1;
    end
  end

  always_comb begin
    raddr = pidx_r[AW-1:0];
    if (!req_r.from_peak || cmd.bound || cmd.sum_step || cmd.sqrt_step || cmd.sqrt_acc)
      raddr = cmd.bound ? st_w[AW-1:0] : cur_r[AW-1:0];
    if (cmd.sqrt_acc) raddr = AW'(cur_r + 1'b1);
    if (cmd.sum_step && !rd_wait_r && req_r.coherent) raddr = AW'(cur_r + 1'b1);
    if (cmd.peak_step || cmd.peak_start) raddr = cmd.peak_start ? '0 : pidx_r[AW-1:0];
  end

  assign sts.clr_done  = (clr_r == (AW+1)'(MAX_TAPS - 1)) && cmd.clr_step;
  assign sts.div_done  = (dcnt_r == 6'd34);
  assign sts.peak_done = cmd.peak_step && !pvld_r && !(pidx_r < (CW+1)'(cnt_r));
  // window finished once the cursor reaches the clipped end
  assign sts.sum_done  = !(cur_r < en_r);
  assign sts.sqrt_done = (sbit_r == '0);
  assign sts.res_zero  = (res_ticks == '0);
  assign sts.is_query  = (req_r.op == OP_QUERY);
  assign sts.from_peak = req_r.from_peak;
  assign sts.coherent  = req_r.coherent;

  always_comb begin
    result.sum_re  = req_r.coherent ? acc_re_r : '0;
    result.sum_im  = req_r.coherent ? acc_im_r : '0;
    result.sum_mag = req_r.coherent ? '0 : acc_mag_r;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sum_step && !rd_wait_r && cur_r < en_r |-> cur_r < 36'(MAX_TAPS))
    else $error("tap read beyond store");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.peak_step && pvld_r |-> {1'b0, pcand_r} < (AW+1)'(cnt_r))
    else $error("peak candidate outside tap count");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_acc |-> !req_r.coherent)
    else $error("magnitude added on coherent query");

endmodule

// ----- rtl/delay_profile_window_summer_core.sv -----
// delay profile window summer
// in channel: in_valid / in_stall / in_data carry one request, either a tap
//   write (op 0) or a window sum query (op 1)
// out channel: out_valid / out_stall / out_data carry one result per query,
//   writes give no result
// cfg channel: cfg_valid / cfg_ready / cfg_data write resolution_ticks,
//   taken only while the block is idle
// timing: a query runs two 34-step divisions (skipped when resolution is zero),
//   then a peak scan over the stored taps when anchored, then a pass over
//   the window taps, coherent or with a bitwise square root per tap for
//   magnitude, all on one RAM port
// one request is in flight at a time; in_stall is high while busy
// reset: tap store is swept to zero, one tap a cycle, after reset; in_stall
//   stays high during the sweep; resolution resets to zero
// out stall: the result holds in its register until out_stall drops
module delay_profile_window_summer_core import dpws_pkg::*; #(
  parameter int MAX_TAPS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dpws_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dpws_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  dpws_cmd_t cmd;
  dpws_sts_t sts;
  logic      busy;
  logic      in_fire;
  logic [31:0] res_r;
  dpws_out_t out_r;
  logic      out_valid_r;
  dpws_out_t result;

  // configuration register, written only between requests
  assign cfg_ready = !busy;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      res_r <= cfg_data;
    end
  end

  // input acceptance only when idle and output slot empty
  assign in_stall = busy || out_valid_r;
  assign in_fire  = in_valid && !in_stall;

  dpws_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(!out_valid_r), .sts(sts), .cmd(cmd), .busy(busy)
  );

  dpws_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .res_ticks(res_r),
    .cmd(cmd), .sts(sts), .result(result)
  );

  // result register, holds under stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.emit) out_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("second request accepted");

endmodule
